@@ hdl/psu_pkg.sv @@
package psu_pkg;

	localparam int BOARD_SIDE = 8;
	localparam int SQUARES    = BOARD_SIDE * BOARD_SIDE;
	localparam int FIELD_W    = 6;
	localparam int COORD_W    = 3;
	localparam int OUT_COORD_W = 4;
	localparam int LEN_W      = 15;

	// Position of a byte within its group of three.
	localparam logic [1:0] PHASE_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_SECOND = 2'd1;
	localparam logic [1:0] PHASE_THIRD  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_PATH_LENGTH = 1'b0;

	localparam logic [LEN_W-1:0] PATH_LENGTH_RESET = 15'd64;

	// One byte's worth of work: one position, or two for the third byte of a group.
	typedef struct packed {
		logic [FIELD_W-1:0] field0;
		logic               last0;
		logic               has1;
		logic [FIELD_W-1:0] field1;
		logic               last1;
	} psu_entry_t;

	localparam int ENTRY_W = $bits(psu_entry_t);

endpackage

@@ hdl/psu_front.sv @@
module psu_front
	import psu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LEN_W-1:0] path_length,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       packed_byte,
	output logic             push_valid,
	input  logic             push_ready,
	output psu_entry_t       push_entry
);

	logic [1:0]       phase_q;
	logic [7:0]       carry_q;
	logic [LEN_W-1:0] count_q;

	logic [LEN_W:0] count_plus1;
	logic [LEN_W:0] count_plus2;
	logic [LEN_W:0] length_ext;
	logic [1:0]     phase_next;
	logic           path_done;
	logic           accept;

	assign in_ready    = push_ready;
	assign push_valid  = in_valid;
	assign accept      = in_valid && push_ready;
	assign count_plus1 = {1'b0, count_q} + {{LEN_W{1'b0}}, 1'b1};
	assign count_plus2 = {1'b0, count_q} + {{(LEN_W-1){1'b0}}, 2'd2};
	assign length_ext  = {1'b0, path_length};

	always_comb begin
		push_entry.field0 = packed_byte[7:2];
		push_entry.last0  = count_plus1 >= length_ext;
		push_entry.has1   = 1'b0;
		push_entry.field1 = packed_byte[5:0];
		push_entry.last1  = 1'b0;
		phase_next        = PHASE_SECOND;
		case (phase_q)
			PHASE_SECOND: begin
				push_entry.field0 = {carry_q[1:0], packed_byte[7:4]};
				phase_next        = PHASE_THIRD;
			end
			PHASE_THIRD: begin
				push_entry.field0 = {carry_q[3:0], packed_byte[7:6]};
				push_entry.has1   = !push_entry.last0;
				push_entry.last1  = !push_entry.last0 && (count_plus2 >= length_ext);
				phase_next        = PHASE_FIRST;
			end
			default: begin
				push_entry.field0 = packed_byte[7:2];
				phase_next        = PHASE_SECOND;
			end
		endcase
		path_done = push_entry.last0 || push_entry.last1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_FIRST;
			carry_q <= 8'd0;
			count_q <= '0;
		end else if (accept) begin
			if (path_done) begin
				phase_q <= PHASE_FIRST;
				carry_q <= 8'd0;
				count_q <= '0;
			end else begin
				phase_q <= phase_next;
				carry_q <= packed_byte;
				count_q <= push_entry.has1 ? count_plus2[LEN_W-1:0] : count_plus1[LEN_W-1:0];
			end
		end
	end

endmodule

@@ hdl/psu_fifo.sv @@
module psu_fifo
	import psu_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  psu_entry_t push_entry,
	output logic       pop_valid,
	input  logic       pop_ready,
	output psu_entry_t pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	psu_entry_t       store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != FULL_CNT;
	assign pop_valid  = count_q != '0;
	assign pop_entry  = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/psu_back.sv @@
module psu_back
	import psu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  psu_entry_t             pop_entry,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_COORD_W-1:0] square_row,
	output logic [OUT_COORD_W-1:0] square_col,
	output logic                   path_end,
	output logic                   board_covered
);

	logic                   out_valid_q;
	logic [OUT_COORD_W-1:0] row_q;
	logic [OUT_COORD_W-1:0] col_q;
	logic                   end_q;
	logic                   covered_q;
	logic                   sel_q;
	logic [SQUARES-1:0]     map_q;

	logic [FIELD_W-1:0] field;
	logic               last;
	logic [SQUARES-1:0] map_next;
	logic               load;

	assign field     = sel_q ? pop_entry.field1 : pop_entry.field0;
	assign last      = sel_q ? pop_entry.last1 : pop_entry.last0;
	// The six-bit field is row * 8 + column, so it indexes the map directly.
	assign map_next  = map_q | ({{(SQUARES-1){1'b0}}, 1'b1} << field);
	assign load      = pop_valid && (!out_valid_q || out_ready);
	assign pop_ready = load && (sel_q || !pop_entry.has1);

	assign out_valid     = out_valid_q;
	assign square_row    = row_q;
	assign square_col    = col_q;
	assign path_end      = end_q;
	assign board_covered = covered_q;

	always_ff @(posedge clk) begin
		if (load) begin
			row_q     <= {1'b0, field[FIELD_W-1:COORD_W]} + OUT_COORD_W'(1);
			col_q     <= {1'b0, field[COORD_W-1:0]} + OUT_COORD_W'(1);
			end_q     <= last;
			covered_q <= last && (&map_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			map_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sel_q       <= sel_q ? 1'b0 : pop_entry.has1;
				map_q       <= last ? '0 : map_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/packed_square_unpacker_with_coverage_core.sv @@
// An accepted byte is written into the queue, and its first position then passes into the
// back end's output register, which drives out_valid.
// Throughput: one byte per cycle until the queue fills; the third byte of a group may give two
// positions, which leave the single result register one after the other.
// Reset: arst_n clears the byte phase, count, visited map, queue and output valid at once,
// and sets path_length to 64.
module packed_square_unpacker_with_coverage_core
	import psu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             packed_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_COORD_W-1:0] square_row,
	output logic [OUT_COORD_W-1:0] square_col,
	output logic                   path_end,
	output logic                   board_covered
);

	// The single register sits at byte address zero. Bit two of the address picks the
	// register index; writes to the empty upper word are ignored and it reads as zero.
	logic [LEN_W-1:0] path_length_q;
	logic             reg_write;

	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && (paddr[2] == REG_PATH_LENGTH);
	assign prdata    = (paddr[2] == REG_PATH_LENGTH) ?
		{{(32-LEN_W){1'b0}}, path_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_length_q <= PATH_LENGTH_RESET;
		end else if (reg_write) begin
			path_length_q <= pwdata[LEN_W-1:0];
		end
	end

	// The front end unpacks each byte into one or two six-bit positions and decides,
	// from its own position count, which of them closes the path. Doing the count here
	// means the byte phase can restart on the very next byte without waiting on the
	// back end. A path-ending third position suppresses the fourth of its group.
	psu_entry_t push_entry;
	psu_entry_t pop_entry;
	logic       push_valid;
	logic       push_ready;
	logic       pop_valid;
	logic       pop_ready;

	psu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.path_length (path_length_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.packed_byte (packed_byte),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_entry  (push_entry)
	);

	// A short queue decouples the two halves, so a stalled result port does not stop
	// bytes from being taken until the queue itself has filled.
	psu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// The back end issues the positions through its output register, one per cycle while
	// out_ready allows, keeps the visited map and raises board_covered on the last position
	// when every square has been marked. The map is cleared as the last position is issued.
	psu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_entry     (pop_entry),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.square_row    (square_row),
		.square_col    (square_col),
		.path_end      (path_end),
		.board_covered (board_covered)
	);

endmodule

@@ verif/tb_packed_square_unpacker_with_coverage_core.sv @@
module tb_packed_square_unpacker_with_coverage_core;
	import psu_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Each register sits at four times its index on the byte-addressed port.
	localparam logic [2:0] PATH_LENGTH_ADDR = {REG_PATH_LENGTH, 2'b00};

	// Number of input items after which the random part ends.
	localparam int ITEM_BUDGET = 900;
	// From this item count onwards neither side idles any more.
	localparam int CALM_AFTER = 780;

	// One unpacked board position, as it leaves the block.
	typedef struct packed {
		logic [OUT_COORD_W-1:0] row;
		logic [OUT_COORD_W-1:0] col;
		logic                   last;
		logic                   covered;
	} square_t;

	typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

	// One line of the directed table. For a byte row with typed set, the first
	// position it produces must equal want; otherwise the predictor decides.
	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] value;
		logic        typed;
		square_t     want;
	} stim_row_t;

	localparam square_t NO_CHECK = '0;

	// The directed part. The block comes out of reset with a path length of 64.
	// The rows walk through the extremes of the byte, a zero length (every
	// position closes a path), a length lowered once a path is already past it,
	// a path whose end falls on the third position of a group so that the
	// fourth is dropped, and the largest length the register holds. Writes with
	// upper bits set check that only the low fifteen bits of the data count.
	localparam int DIRECTED_ROWS = 25;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_BYTE,  32'h0000_0000, 1'b1, '{4'd1, 4'd1, 1'b0, 1'b0}},
		'{ROW_BYTE,  32'h0000_00ff, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_00ff, 1'b1, '{4'd8, 4'd8, 1'b0, 1'b0}},
		'{ROW_WRITE, 32'h0000_0000, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_00fc, 1'b1, '{4'd8, 4'd8, 1'b1, 1'b0}},
		'{ROW_BYTE,  32'h0000_0003, 1'b1, '{4'd1, 4'd1, 1'b1, 1'b0}},
		'{ROW_WRITE, 32'h0000_0040, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_005a, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_00c3, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_0096, 1'b0, NO_CHECK},
		'{ROW_WRITE, 32'h0000_0002, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_0000, 1'b1, '{4'd1, 4'd1, 1'b1, 1'b0}},
		'{ROW_WRITE, 32'h0000_0003, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_0000, 1'b1, '{4'd1, 4'd1, 1'b0, 1'b0}},
		'{ROW_BYTE,  32'h0000_0000, 1'b1, '{4'd1, 4'd1, 1'b0, 1'b0}},
		'{ROW_BYTE,  32'h0000_00ff, 1'b1, '{4'd1, 4'd4, 1'b1, 1'b0}},
		'{ROW_WRITE, 32'hffff_ffff, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_00a5, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_003c, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_00e7, 1'b0, NO_CHECK},
		'{ROW_WRITE, 32'h0000_8001, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_0000, 1'b1, '{4'd1, 4'd1, 1'b1, 1'b0}},
		'{ROW_BYTE,  32'h0000_0024, 1'b1, '{4'd2, 4'd2, 1'b1, 1'b0}},
		'{ROW_WRITE, 32'h0000_8000, 1'b0, NO_CHECK},
		'{ROW_BYTE,  32'h0000_00ff, 1'b1, '{4'd8, 4'd8, 1'b1, 1'b0}}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [2:0]             paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             packed_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [OUT_COORD_W-1:0] square_row;
	logic [OUT_COORD_W-1:0] square_col;
	logic                   path_end;
	logic                   board_covered;

	packed_square_unpacker_with_coverage_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packed_byte  (packed_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.square_row   (square_row),
		.square_col   (square_col),
		.path_end     (path_end),
		.board_covered(board_covered)
	);

	// Our own copy of the unpacker state, kept in step with every accepted item
	// and every register write.
	logic [1:0]       group_phase;
	logic [7:0]       carried_byte;
	logic [LEN_W-1:0] path_count;
	logic [LEN_W-1:0] path_len;
	logic [SQUARES-1:0] visited_squares;

	// Positions that the block still owes us, oldest first.
	square_t expected_squares[$];

	int failures;
	int bytes_sent;
	// Set for the last stretch of the run, in which nobody idles.
	bit calm;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	function automatic void clear_path();
		group_phase     = PHASE_FIRST;
		carried_byte    = '0;
		path_count      = '0;
		visited_squares = '0;
	endfunction

	// Records one six-bit position and queues the square it should come out as.
	// The field is row times eight plus column, so it doubles as the map index.
	// Returns whether this position closes the path.
	function automatic bit record_square(input logic [FIELD_W-1:0] field);
		bit      ended;
		square_t sq;
		visited_squares[field] = 1'b1;
		ended      = (int'(path_count) + 1) >= int'(path_len);
		sq.row     = {1'b0, field[5:3]} + 4'd1;
		sq.col     = {1'b0, field[2:0]} + 4'd1;
		sq.last    = ended;
		sq.covered = ended && (&visited_squares);
		expected_squares.push_back(sq);
		if (ended) begin
			clear_path();
		end else begin
			path_count = path_count + 1'b1;
		end
		return ended;
	endfunction

	// A byte always gives one position; the third byte of a group gives a
	// second one unless the first of the two has already closed the path.
	function automatic void unpack_byte(input logic [7:0] b);
		logic [7:0] prev;
		prev = carried_byte;
		case (group_phase)
		PHASE_SECOND: begin
			group_phase  = PHASE_THIRD;
			carried_byte = b;
			void'(record_square({prev[1:0], b[7:4]}));
		end
		PHASE_THIRD: begin
			group_phase  = PHASE_FIRST;
			carried_byte = b;
			if (!record_square({prev[3:0], b[7:6]})) begin
				void'(record_square(b[5:0]));
			end
		end
		default: begin
			group_phase  = PHASE_SECOND;
			carried_byte = b;
			void'(record_square(b[7:2]));
		end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Driving. Every task here starts and ends just after a falling edge.
	// ---------------------------------------------------------------------

	// Offers one byte and holds it until the block takes it. Unless the task
	// then pauses at random, the valid line is left high on return, so a following
	// byte goes out without a bubble; drain lowers it before a register write.
	task automatic send_byte(input logic [7:0] b, input logic typed, input square_t want);
		int first;
		in_valid    <= 1'b1;
		packed_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		first = expected_squares.size();
		unpack_byte(b);
		// Where the table gives the first position outright, that is what we
		// hold the block to; the predictor has still moved its state on.
		if (typed) begin
			expected_squares[first] = want;
		end
		bytes_sent++;
		if (bytes_sent >= CALM_AFTER) begin
			calm = 1'b1;
		end
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	// Stops offering items and waits until every owed position has come out,
	// so that the block is idle before its register is touched.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_squares.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Setup cycle, then access cycle; the write lands at the rising edge of
	// the access cycle, since pready is always high.
	task automatic write_path_length(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PATH_LENGTH_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		path_len = value[LEN_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Packs a path of the given number of positions into bytes and sends them.
	// A tour path starts with every square of the board in shuffled order, so
	// that with a length of 64 or more the coverage flag must come up. Bits
	// past the last position of the path are filled with noise, since the
	// block drops them.
	task automatic send_path(input int positions, input bit tour);
		logic [FIELD_W-1:0] order [SQUARES];
		logic [FIELD_W-1:0] fields[$];
		logic [FIELD_W-1:0] swap;
		logic [23:0]        group;
		int                 j;
		int                 byte_count;
		for (int i = 0; i < SQUARES; i++) begin
			order[i] = FIELD_W'(i);
		end
		for (int i = SQUARES - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			swap     = order[i];
			order[i] = order[j];
			order[j] = swap;
		end
		for (int i = 0; i < positions + 3; i++) begin
			fields.push_back((tour && i < SQUARES) ? order[i] : FIELD_W'($urandom));
		end
		byte_count = (FIELD_W * positions + 7) / 8;
		for (int i = 0; i < byte_count; i++) begin
			j     = (i / 3) * 4;
			group = {fields[j], fields[j + 1], fields[j + 2], fields[j + 3]};
			send_byte(group[23 - 8 * (i % 3) -: 8], 1'b0, NO_CHECK);
		end
	endtask

	// One random phase: pick a path length, write it while the block is idle,
	// then send a batch of paths at that length. Very long lengths never close
	// a path within the batch, so they get plain random bytes instead, and the
	// next phase then meets a path already part way through.
	task automatic run_phase();
		logic [LEN_W-1:0] len;
		logic [31:0]      value;
		int               budget;
		int               start;
		case ($urandom_range(0, 9))
		0, 1:    len = LEN_W'(64);
		2:       len = LEN_W'(1);
		3:       len = '0;
		4:       len = '1;
		5:       len = LEN_W'($urandom_range(2, 12));
		6:       len = LEN_W'($urandom_range(13, 63));
		7:       len = LEN_W'($urandom_range(65, 140));
		8:       len = LEN_W'(3);
		default: len = LEN_W'($urandom_range(1, 32767));
		endcase
		value = {$urandom_range(0, 1) == 0 ? 17'd0 : 17'($urandom), len};
		drain();
		write_path_length(value);
		budget = $urandom_range(30, 120);
		start  = bytes_sent;
		while (bytes_sent - start < budget) begin
			if (len > LEN_W'(160)) begin
				send_byte(8'($urandom), 1'b0, NO_CHECK);
			end else begin
				send_path(len == '0 ? 1 : int'(len),
					len >= LEN_W'(64) && $urandom_range(0, 2) != 0);
			end
		end
	endtask

	// ---------------------------------------------------------------------
	// Receiving side: out_ready runs high for a while, then drops for a burst of random
	// length. Towards the end it stays high for good.
	// ---------------------------------------------------------------------

	initial begin
		int  hold_left;
		bit  stalling;
		hold_left = 0;
		stalling  = 1'b0;
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_left == 0) begin
				if (!calm && $urandom_range(0, 3) == 0) begin
					stalling  = 1'b1;
					hold_left = $urandom_range(1, 8);
				end else begin
					stalling  = 1'b0;
					hold_left = $urandom_range(1, 24);
				end
			end
			out_ready <= calm ? 1'b1 : !stalling;
			hold_left--;
		end
	end

	// Every position handed over is held against the oldest one we predicted.
	always @(posedge clk) begin
		square_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_squares.size() == 0) begin
				$error("unexpected position: square_row %0d square_col %0d path_end %0d",
					square_row, square_col, path_end);
				failures++;
			end else begin
				want = expected_squares.pop_front();
				if (square_row !== want.row) begin
					$error("square_row: expected %0d, got %0d", want.row, square_row);
					failures++;
				end
				if (square_col !== want.col) begin
					$error("square_col: expected %0d, got %0d", want.col, square_col);
					failures++;
				end
				if (path_end !== want.last) begin
					$error("path_end: expected %0d, got %0d", want.last, path_end);
					failures++;
				end
				if (board_covered !== want.covered) begin
					$error("board_covered: expected %0d, got %0d",
						want.covered, board_covered);
					failures++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------

	initial begin
		int waited;
		failures    = 0;
		bytes_sent  = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		packed_byte = '0;
		path_len    = PATH_LENGTH_RESET;
		clear_path();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The directed table first; writes wait for the block to go idle.
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (DIRECTED[r].kind == ROW_WRITE) begin
				drain();
				write_path_length(DIRECTED[r].value);
			end else begin
				send_byte(DIRECTED[r].value[7:0], DIRECTED[r].typed, DIRECTED[r].want);
			end
		end

		// Then random phases until the item budget is spent.
		while (bytes_sent < ITEM_BUDGET) begin
			run_phase();
		end
		in_valid <= 1'b0;

		// Let the last positions drain out, then give the block a few more
		// cycles in which anything extra would show up as unexpected.
		waited = 0;
		while (expected_squares.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_squares.size() != 0) begin
			$error("%0d positions never came out", expected_squares.size());
			failures++;
		end

		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog. It ends the run after 10 ms, far longer than a correct run of about a
	// thousand items needs even with every input gap and output stall at its longest.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
